// ===== rtl/layer_zorder_stack_manager_defines.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef LAYER_ZORDER_STACK_MANAGER_DEFINES_SVH
`define LAYER_ZORDER_STACK_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define LZSM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lzsm check failed");

// Clocked check that also holds through reset.
`define LZSM_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lzsm check failed");

`else

`define LZSM_ASSERT(label, clk, rst_n, prop)
`define LZSM_ASSERT_NR(label, clk, prop)

`endif

`endif

// ===== rtl/lzsm_pkg.sv =====
package lzsm_pkg;

  localparam int ID_W      = 8;
  localparam int REQ_W     = 10;
  localparam int OUT_HGT_W = 9;
  localparam int OUT_CNT_W = 9;

  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_SET_HEIGHT = 2'd1,
    REQ_FREE       = 2'd2,
    REQ_NOP        = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  // Write strobes from the sequencer to the layer store.
  typedef struct packed {
    logic taken_set;
    logic taken_clr;
    logic hgt_we;
    logic ord_we;
  } mem_cmd_t;

endpackage

// ===== rtl/lzsm_step.sv =====
module lzsm_step #(
  parameter int IW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          adv_i,
  input  logic          dn_i,
  input  logic [IW-1:0] start_i,
  input  logic [IW-1:0] end_i,
  output logic [IW-1:0] cur_o,
  output logic          last_o
);

  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] end_q, end_d;
  logic          dn_q, dn_d;

  // Shared up/down stepper for the slot scan and the stack shift.
  always_comb begin
    cur_d = cur_q;
    end_d = end_q;
    dn_d  = dn_q;
    if (load_i) begin
      cur_d = start_i;
      end_d = end_i;
      dn_d  = dn_i;
    end else if (adv_i) begin
      cur_d = dn_q ? cur_q - IW'(1) : cur_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      end_q <= '0;
      dn_q  <= 1'b0;
    end else begin
      cur_q <= cur_d;
      end_q <= end_d;
      dn_q  <= dn_d;
    end
  end

  assign cur_o  = cur_q;
  assign last_o = (cur_q == end_q);

endmodule

// ===== rtl/lzsm_store.sv =====
module lzsm_store #(
  parameter int SLOTS = 256,
  parameter int IW    = 8,
  parameter int HW    = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lzsm_pkg::mem_cmd_t    cmd_i,
  input  logic [IW-1:0]         taken_addr_i,
  output logic                  taken_o,
  input  logic [IW-1:0]         hgt_raddr_i,
  output logic signed [HW-1:0]  hgt_rdata_o,
  input  logic [IW-1:0]         hgt_waddr_i,
  input  logic signed [HW-1:0]  hgt_wdata_i,
  input  logic [IW-1:0]         ord_raddr_i,
  output logic [IW-1:0]         ord_rdata_o,
  input  logic [IW-1:0]         ord_waddr_i,
  input  logic [IW-1:0]         ord_wdata_i
);

  logic [SLOTS-1:0]     taken_q, taken_d;
  logic signed [HW-1:0] hgt_mem [SLOTS];
  logic [IW-1:0]        ord_mem [SLOTS];
  logic signed [HW-1:0] hgt_rdata_q;
  logic [IW-1:0]        ord_rdata_q;

  // Slot-in-use flags; reset frees every slot.
  always_comb begin
    taken_d = taken_q;
    if (cmd_i.taken_set) begin
      taken_d[taken_addr_i] = 1'b1;
    end else if (cmd_i.taken_clr) begin
      taken_d[taken_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else begin
      taken_q <= taken_d;
    end
  end

  assign taken_o = taken_q[taken_addr_i];

  // Height per slot; only meaningful while the slot is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hgt_we) begin
      hgt_mem[hgt_waddr_i] <= hgt_wdata_i;
    end
    hgt_rdata_q <= hgt_mem[hgt_raddr_i];
  end

  // Layer id at each stack height, bottom to top.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_we) begin
      ord_mem[ord_waddr_i] <= ord_wdata_i;
    end
    ord_rdata_q <= ord_mem[ord_raddr_i];
  end

  assign hgt_rdata_o = hgt_rdata_q;
  assign ord_rdata_o = ord_rdata_q;

endmodule

// ===== rtl/layer_zorder_stack_manager.sv =====
// Layer z-order stack manager: keeps a pool of LAYER_SLOTS display layers and the
// bottom-to-top order of the visible ones, taking one request at a time and
// returning one result word per request. in_stall_o stays high from the accept
// until the result is loaded into the output register; a result still waiting
// there does not hold off the next request. Allocate scans the slot flags from
// slot 0 up to the first free one, one slot flag per cycle through the shared
// step counter. Set-height and free shift the layers between the old and new
// height by one place (none shift when the height is unchanged), since the stack
// order memory moves one entry per cycle (read and write pipelined on its single
// port pair).
`include "layer_zorder_stack_manager_defines.svh"

module layer_zorder_stack_manager #(
  parameter int LAYER_SLOTS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [lzsm_pkg::ID_W-1:0]        layer_id_i,
  input  logic signed [lzsm_pkg::REQ_W-1:0] requested_height_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [lzsm_pkg::ID_W-1:0]        result_id_o,
  output logic signed [lzsm_pkg::OUT_HGT_W-1:0] new_height_o,
  output logic [lzsm_pkg::OUT_CNT_W-1:0]   shown_count_o,
  output logic                             redraw_o
);

  localparam int IW = $clog2(LAYER_SLOTS);
  localparam int HW = IW + 1;
  localparam int RW = IW + 2;
  localparam int CW = (RW > lzsm_pkg::REQ_W) ? RW : lzsm_pkg::REQ_W;
  localparam logic [IW:0] SLOTS_W = (IW + 1)'(LAYER_SLOTS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOKUP = 8'b0000_0010,
    S_SETUP  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_SHIFT  = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_PLACE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic [IW:0]  vis_q, vis_d;
  logic         pend_q, pend_d;
  logic         out_valid_q, out_valid_d;

  // Working and result payload
  lzsm_pkg::req_type_e             type_q, type_d;
  logic [lzsm_pkg::ID_W-1:0]       id_q, id_d;
  logic signed [lzsm_pkg::REQ_W-1:0] rq_q, rq_d;
  logic signed [HW-1:0]            old_q, old_d;
  logic signed [RW-1:0]            req_q, req_d;
  logic                            hide_q, hide_d;
  logic                            ins_q, ins_d;
  logic [IW-1:0]                   dst_q, dst_d;
  logic [IW-1:0]                   wr_dst_q, wr_dst_d;
  lzsm_pkg::status_e               res_status_q, res_status_d;
  logic [lzsm_pkg::ID_W-1:0]       res_rid_q, res_rid_d;
  logic signed [HW-1:0]            res_hgt_q, res_hgt_d;
  logic                            res_redraw_q, res_redraw_d;
  logic [1:0]                      out_status_q, out_status_d;
  logic [lzsm_pkg::ID_W-1:0]       out_rid_q, out_rid_d;
  logic signed [lzsm_pkg::OUT_HGT_W-1:0] out_hgt_q, out_hgt_d;
  logic [lzsm_pkg::OUT_CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic                            out_redraw_q, out_redraw_d;

  // Store and step unit hookup
  lzsm_pkg::mem_cmd_t   cmd;
  logic [IW-1:0]        taken_addr;
  logic                 taken_rd;
  logic signed [HW-1:0] hgt_rdata;
  logic [IW-1:0]        hgt_waddr;
  logic signed [HW-1:0] hgt_wdata;
  logic [IW-1:0]        ord_rdata;
  logic [IW-1:0]        ord_waddr;
  logic [IW-1:0]        ord_wdata;
  logic                 step_load;
  logic                 step_adv;
  logic                 step_dn;
  logic [IW-1:0]        step_start;
  logic [IW-1:0]        step_end;
  logic [IW-1:0]        step_cur;
  logic                 step_last;

  // Lookup and clamp
  logic [IW-1:0]        id_idx;
  logic                 in_range;
  logic                 valid_w;
  logic signed [HW-1:0] old_w;
  logic signed [CW-1:0] vis_c;
  logic signed [CW-1:0] limit_c;
  logic signed [CW-1:0] req_c;
  logic signed [CW-1:0] creq_c;

  // Move setup
  logic signed [RW-1:0] old_r;
  logic signed [RW-1:0] vis_r;
  logic                 move_dn;
  logic                 move_hide;
  logic                 move_ins;
  logic                 out_free;

  lzsm_store #(
    .SLOTS (LAYER_SLOTS),
    .IW    (IW),
    .HW    (HW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .taken_addr_i (taken_addr),
    .taken_o      (taken_rd),
    .hgt_raddr_i  (IW'(layer_id_i)),
    .hgt_rdata_o  (hgt_rdata),
    .hgt_waddr_i  (hgt_waddr),
    .hgt_wdata_i  (hgt_wdata),
    .ord_raddr_i  (step_cur),
    .ord_rdata_o  (ord_rdata),
    .ord_waddr_i  (ord_waddr),
    .ord_wdata_i  (ord_wdata)
  );

  lzsm_step #(
    .IW (IW)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_load),
    .adv_i   (step_adv),
    .dn_i    (step_dn),
    .start_i (step_start),
    .end_i   (step_end),
    .cur_o   (step_cur),
    .last_o  (step_last)
  );

  assign id_idx   = IW'(id_q);
  assign in_range = (32'(id_q) < 32'(LAYER_SLOTS));
  assign valid_w  = in_range && taken_rd;
  // A slot that is not taken always reads as hidden.
  assign old_w    = valid_w ? hgt_rdata : '1;

  assign vis_c   = CW'(vis_q);
  assign limit_c = old_w[HW-1] ? vis_c : vis_c - CW'(1);
  assign req_c   = CW'(rq_q);
  always_comb begin
    creq_c = (req_c > limit_c) ? limit_c : req_c;
    if (creq_c[CW-1]) begin
      creq_c = '1;
    end
  end

  assign old_r     = RW'(old_q);
  assign vis_r     = RW'(vis_q);
  assign move_dn   = (req_q < old_r);
  assign move_hide = req_q[RW-1];
  assign move_ins  = old_q[HW-1];

  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    vis_d        = vis_q;
    pend_d       = pend_q;
    type_d       = type_q;
    id_d         = id_q;
    rq_d         = rq_q;
    old_d        = old_q;
    req_d        = req_q;
    hide_d       = hide_q;
    ins_d        = ins_q;
    dst_d        = dst_q;
    wr_dst_d     = wr_dst_q;
    res_status_d = res_status_q;
    res_rid_d    = res_rid_q;
    res_hgt_d    = res_hgt_q;
    res_redraw_d = res_redraw_q;
    out_status_d = out_status_q;
    out_rid_d    = out_rid_q;
    out_hgt_d    = out_hgt_q;
    out_cnt_d    = out_cnt_q;
    out_redraw_d = out_redraw_q;
    out_valid_d  = out_valid_q && out_stall_i;

    cmd        = '0;
    taken_addr = id_idx;
    hgt_waddr  = id_idx;
    hgt_wdata  = '1;
    ord_waddr  = wr_dst_q;
    ord_wdata  = ord_rdata;
    step_load  = 1'b0;
    step_adv   = 1'b0;
    step_dn    = 1'b0;
    step_start = '0;
    step_end   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          type_d  = lzsm_pkg::req_type_e'(req_type_i);
          id_d    = layer_id_i;
          rq_d    = requested_height_i;
          state_d = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        old_d        = old_w;
        res_status_d = lzsm_pkg::ST_OK;
        res_rid_d    = id_q;
        res_hgt_d    = '1;
        res_redraw_d = 1'b0;
        case (type_q) inside
          lzsm_pkg::REQ_ALLOC: begin
            res_rid_d  = '0;
            step_load  = 1'b1;
            step_start = '0;
            step_end   = IW'(LAYER_SLOTS - 1);
            state_d    = S_SCAN;
          end
          lzsm_pkg::REQ_SET_HEIGHT, lzsm_pkg::REQ_FREE: begin
            if (!valid_w) begin
              res_status_d = lzsm_pkg::ST_NOT_ALLOC;
              state_d      = S_FINISH;
            end else if (type_q == lzsm_pkg::REQ_FREE && old_w[HW-1]) begin
              // Hidden layer: just release the slot.
              cmd.taken_clr = 1'b1;
              state_d       = S_FINISH;
            end else begin
              req_d   = (type_q == lzsm_pkg::REQ_FREE) ? '1 : RW'(creq_c);
              state_d = S_SETUP;
            end
          end
          default: begin
            res_hgt_d = old_w;
            state_d   = S_FINISH;
          end
        endcase
      end

      S_SETUP: begin
        pend_d = 1'b0;
        hide_d = move_hide;
        ins_d  = move_ins;
        if (req_q == old_r) begin
          res_hgt_d = old_q;
          state_d   = S_FINISH;
        end else begin
          step_load = 1'b1;
          dst_d     = IW'(old_r);
          if (move_dn && !move_hide) begin
            // Sink: layers from req up to old-1 move up one place.
            step_dn    = 1'b1;
            step_start = IW'(old_r - RW'(1));
            step_end   = IW'(req_q);
            state_d    = S_SHIFT;
          end else if (move_dn) begin
            // Hide: layers above old move down one place.
            step_start = IW'(old_r + RW'(1));
            step_end   = IW'(vis_r - RW'(1));
            state_d    = (old_r == vis_r - RW'(1)) ? S_PLACE : S_SHIFT;
          end else if (!move_ins) begin
            // Raise: layers from old+1 up to req move down one place.
            step_start = IW'(old_r + RW'(1));
            step_end   = IW'(req_q);
            state_d    = S_SHIFT;
          end else begin
            // Show: layers from req up to the top move up one place.
            step_dn    = 1'b1;
            step_start = IW'(vis_r - RW'(1));
            step_end   = IW'(req_q);
            dst_d      = IW'(vis_r);
            state_d    = (req_q == vis_r) ? S_PLACE : S_SHIFT;
          end
        end
      end

      S_SCAN: begin
        taken_addr = step_cur;
        hgt_waddr  = step_cur;
        if (!taken_rd) begin
          cmd.taken_set = 1'b1;
          cmd.hgt_we    = 1'b1;
          res_rid_d     = lzsm_pkg::ID_W'(step_cur);
          state_d       = S_FINISH;
        end else if (step_last) begin
          res_status_d = lzsm_pkg::ST_NO_SLOT;
          state_d      = S_FINISH;
        end else begin
          step_adv = 1'b1;
        end
      end

      S_SHIFT, S_DRAIN: begin
        // Write back the entry read last cycle and renumber its height.
        hgt_waddr  = ord_rdata;
        hgt_wdata  = HW'(wr_dst_q);
        cmd.ord_we = pend_q;
        cmd.hgt_we = pend_q;
        if (state_q == S_SHIFT) begin
          wr_dst_d = dst_q;
          dst_d    = step_cur;
          pend_d   = 1'b1;
          if (step_last) begin
            state_d = S_DRAIN;
          end else begin
            step_adv = 1'b1;
          end
        end else begin
          pend_d  = 1'b0;
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        cmd.hgt_we = 1'b1;
        if (hide_q) begin
          vis_d     = vis_q - (IW + 1)'(1);
          res_hgt_d = '1;
        end else begin
          cmd.ord_we = 1'b1;
          ord_waddr  = IW'(req_q);
          ord_wdata  = id_idx;
          hgt_wdata  = HW'(req_q);
          res_hgt_d  = HW'(req_q);
          if (ins_q) begin
            vis_d = vis_q + (IW + 1)'(1);
          end
        end
        cmd.taken_clr = (type_q == lzsm_pkg::REQ_FREE);
        res_redraw_d  = 1'b1;
        state_d       = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_rid_d    = res_rid_q;
          out_hgt_d    = lzsm_pkg::OUT_HGT_W'(res_hgt_q);
          out_cnt_d    = lzsm_pkg::OUT_CNT_W'(vis_q);
          out_redraw_d = res_redraw_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vis_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vis_q       <= vis_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q       <= type_d;
    id_q         <= id_d;
    rq_q         <= rq_d;
    old_q        <= old_d;
    req_q        <= req_d;
    hide_q       <= hide_d;
    ins_q        <= ins_d;
    dst_q        <= dst_d;
    wr_dst_q     <= wr_dst_d;
    res_status_q <= res_status_d;
    res_rid_q    <= res_rid_d;
    res_hgt_q    <= res_hgt_d;
    res_redraw_q <= res_redraw_d;
    out_status_q <= out_status_d;
    out_rid_q    <= out_rid_d;
    out_hgt_q    <= out_hgt_d;
    out_cnt_q    <= out_cnt_d;
    out_redraw_q <= out_redraw_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_id_o   = out_rid_q;
  assign new_height_o  = out_hgt_q;
  assign shown_count_o = out_cnt_q;
  assign redraw_o      = out_redraw_q;

  `LZSM_ASSERT_NR(a_vis_bound, clk_i, !rst_ni || vis_q <= SLOTS_W)
  `LZSM_ASSERT(a_accept_lookup, clk_i, rst_ni, in_valid_i && !in_stall_o |=> state_q == S_LOOKUP)
  `LZSM_ASSERT(a_shift_drain, clk_i, rst_ni, state_q == S_SHIFT && step_last |=> state_q == S_DRAIN)
  `LZSM_ASSERT(a_finish_load, clk_i, rst_ni, state_q == S_FINISH && out_free |=> out_valid_q && state_q == S_IDLE)
  `LZSM_ASSERT(a_redraw_ok, clk_i, rst_ni, out_valid_o && redraw_o |-> status_o == lzsm_pkg::ST_OK)

endmodule

// ===== tb/layer_stack_checker.sv =====
module layer_stack_checker
  import lzsm_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  req_type_i,
  input  logic [ID_W-1:0]             layer_id_i,
  input  logic signed [REQ_W-1:0]     requested_height_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  status_i,
  input  logic [ID_W-1:0]             result_id_i,
  input  logic signed [OUT_HGT_W-1:0] new_height_i,
  input  logic [OUT_CNT_W-1:0]        shown_count_i,
  input  logic                        redraw_i,
  output int                          err_count_o,
  output int                          pending_o
);

  typedef struct {
    status_e                     st;
    logic [ID_W-1:0]             id;
    logic signed [OUT_HGT_W-1:0] hgt;
    logic [OUT_CNT_W-1:0]        cnt;
    logic                        redraw;
  } layer_word_t;

  // Shadow of the layer pool.
  bit slot_busy [SLOTS];
  int slot_hgt  [SLOTS];
  int order     [SLOTS];
  int shown;

  layer_word_t want_q [$];
  layer_word_t got_w, want_w;
  int          word_idx = 0;

  task automatic note_error(string msg);
    $display("ERROR t=%0t word %0d: %s", $time, word_idx, msg);
    err_count_o++;
  endtask

  function automatic void set_level(int h, int id);
    if (h >= 0 && h < SLOTS) begin
      order[h] = id;
    end
    slot_hgt[id] = h;
  endfunction

  // Move one layer to a new height; 1 when the stack changed.
  function automatic bit restack(int id, int want);
    int was, top, lim, h;
    was = slot_hgt[id];
    top = shown - 1;
    lim = (was >= 0) ? top : shown;
    if (want > lim) want = lim;
    if (want < -1) want = -1;
    if (was == want) return 1'b0;
    if (was > want && want >= 0) begin
      for (h = was; h > want; h--) set_level(h, order[h-1]);
      set_level(want, id);
    end else if (was > want) begin
      // hide: close the gap above the old position
      for (h = was; h < top; h++) set_level(h, order[h+1]);
      slot_hgt[id] = -1;
      if (shown > 0) shown--;
    end else if (was >= 0) begin
      for (h = was; h < want; h++) set_level(h, order[h+1]);
      set_level(want, id);
    end else begin
      // show: open a gap at the target height
      for (h = top; h >= want; h--) set_level(h + 1, order[h]);
      set_level(want, id);
      if (shown < SLOTS) shown++;
    end
    return 1'b1;
  endfunction

  function automatic layer_word_t apply_request(req_type_e op, logic [ID_W-1:0] id,
                                                logic signed [REQ_W-1:0] req);
    layer_word_t r;
    bit          found;
    int          i;
    r.st     = ST_OK;
    r.id     = id;
    r.hgt    = '1;
    r.redraw = 1'b0;
    found    = 1'b0;
    case (op)
      REQ_ALLOC: begin
        r.st = ST_NO_SLOT;
        r.id = '0;
        for (i = 0; i < SLOTS; i++) begin
          if (!found && !slot_busy[i]) begin
            found        = 1'b1;
            slot_busy[i] = 1'b1;
            slot_hgt[i]  = -1;
            r.st         = ST_OK;
            r.id         = i[ID_W-1:0];
          end
        end
      end
      REQ_SET_HEIGHT, REQ_FREE: begin
        if (id >= SLOTS || !slot_busy[id]) begin
          r.st = ST_NOT_ALLOC;
        end else if (op == REQ_SET_HEIGHT) begin
          r.redraw = restack(id, int'(req));
          r.hgt    = OUT_HGT_W'(slot_hgt[id]);
        end else begin
          if (slot_hgt[id] >= 0) r.redraw = restack(id, -1);
          slot_busy[id] = 1'b0;
          r.hgt         = OUT_HGT_W'(slot_hgt[id]);
        end
      end
      default: begin
        if (id < SLOTS) r.hgt = OUT_HGT_W'(slot_hgt[id]);
      end
    endcase
    r.cnt = OUT_CNT_W'(shown);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_hgt[i]  = -1;
        order[i]     = 0;
      end
      shown = 0;
      want_q.delete();
    end else begin
      // check the outgoing word before taking a new request
      if (out_valid_i && !out_stall_i) begin
        if (want_q.size() == 0) begin
          note_error("result word with nothing pending");
        end else begin
          want_w = want_q.pop_front();
          if (status_i !== want_w.st)
            note_error($sformatf("status got %0d want %0d", status_i, want_w.st));
          if (result_id_i !== want_w.id)
            note_error($sformatf("result_id got %0d want %0d", result_id_i, want_w.id));
          if (new_height_i !== want_w.hgt)
            note_error($sformatf("new_height got %0d want %0d", new_height_i, want_w.hgt));
          if (shown_count_i !== want_w.cnt)
            note_error($sformatf("shown_count got %0d want %0d", shown_count_i,
                                 want_w.cnt));
          if (redraw_i !== want_w.redraw)
            note_error($sformatf("redraw got %0b want %0b", redraw_i, want_w.redraw));
        end
        word_idx++;
      end
      if (in_valid_i && !in_stall_i) begin
        got_w = apply_request(req_type_e'(req_type_i), layer_id_i, requested_height_i);
        want_q.push_back(got_w);
      end
    end
    pending_o <= want_q.size();
  end

endmodule

// ===== tb/layer_zorder_stack_manager_tb.sv =====
module layer_zorder_stack_manager_tb;
  import lzsm_pkg::*;

  localparam int SLOTS      = 256;
  localparam int RAND_ITEMS = 1830;
  localparam int SEG_LEN    = 230;
  localparam int HOLD_LEN   = 400;
  localparam int LIMIT      = 3_000_000;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  req_type = '0;
  logic [ID_W-1:0]             layer_id = '0;
  logic signed [REQ_W-1:0]     req_hgt  = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  status;
  logic [ID_W-1:0]             result_id;
  logic signed [OUT_HGT_W-1:0] new_height;
  logic [OUT_CNT_W-1:0]        shown_count;
  logic                        redraw;

  int err_count;
  int pending;
  int cycles   = 0;
  int hold_req = 0;
  bit calm     = 1'b0;

  // stimulus-side view of which slots are granted
  bit granted [SLOTS];
  int live = 0;

  layer_zorder_stack_manager #(
    .LAYER_SLOTS(SLOTS)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .layer_id_i         (layer_id),
    .requested_height_i (req_hgt),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .result_id_o        (result_id),
    .new_height_o       (new_height),
    .shown_count_o      (shown_count),
    .redraw_o           (redraw)
  );

  layer_stack_checker #(
    .SLOTS(SLOTS)
  ) u_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .req_type_i         (req_type),
    .layer_id_i         (layer_id),
    .requested_height_i (req_hgt),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .status_i           (status),
    .result_id_i        (result_id),
    .new_height_i       (new_height),
    .shown_count_i      (shown_count),
    .redraw_i           (redraw),
    .err_count_o        (err_count),
    .pending_o          (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending);
      $display("layer_zorder_stack_manager verification failed");
      $finish;
    end
  end

  // Result side: random stall, plus a long hold whenever hold_req advances.
  initial begin
    int seen, left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        left = HOLD_LEN;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 31);
      end
    end
  end

  task automatic push_req(req_type_e op, logic [ID_W-1:0] id, logic signed [REQ_W-1:0] hgt);
    bit found;
    found = 1'b0;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    layer_id <= id;
    req_hgt  <= hgt;
    do @(posedge clk); while (in_stall);
    if (op == REQ_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !granted[i]) begin
          found      = 1'b1;
          granted[i] = 1'b1;
          live++;
        end
      end
    end else if (op == REQ_FREE && granted[id]) begin
      granted[id] = 1'b0;
      live--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_live();
    int start;
    start = $urandom_range(SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (granted[(start + k) % SLOTS]) return ID_W'((start + k) % SLOTS);
    end
    return ID_W'(start);
  endfunction

  function automatic logic signed [REQ_W-1:0] pick_height();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return REQ_W'(int'($urandom_range(live + 2)) - 1);
    if (roll < 75) return REQ_W'(-1);
    if (roll < 85) return REQ_W'($urandom_range(512, 1023));
    return REQ_W'($urandom);
  endfunction

  initial begin
    int goals [8];
    int goal, roll, pa, pf;
    goals = '{3, 60, 256, 256, 20, 200, 256, 1};
    goal = goals[0];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejects and no-op on an empty pool, then three allocations
    push_req(REQ_NOP, 8'd0, 10'sd0);
    push_req(REQ_SET_HEIGHT, 8'd255, 10'sd511);
    push_req(REQ_FREE, 8'd0, -10'sd512);
    push_req(REQ_ALLOC, 8'd255, 10'sd0);
    push_req(REQ_ALLOC, 8'd0, 10'sd0);
    push_req(REQ_ALLOC, 8'd0, 10'sd0);
    // hidden layer clamps to one above the top
    push_req(REQ_SET_HEIGHT, 8'd0, 10'sd511);
    // below -1 on a hidden layer: no change
    push_req(REQ_SET_HEIGHT, 8'd1, -10'sd512);
    push_req(REQ_SET_HEIGHT, 8'd1, 10'sd0);
    push_req(REQ_SET_HEIGHT, 8'd2, 10'sd1);
    push_req(REQ_SET_HEIGHT, 8'd2, 10'sd1);
    push_req(REQ_NOP, 8'd2, -10'sd1);
    // visible layer clamps to the top
    push_req(REQ_SET_HEIGHT, 8'd1, 10'sd300);
    push_req(REQ_SET_HEIGHT, 8'd1, 10'sd0);
    push_req(REQ_SET_HEIGHT, 8'd0, -10'sd1);
    push_req(REQ_SET_HEIGHT, 8'd2, -10'sd2);
    push_req(REQ_FREE, 8'd1, 10'sd0);
    push_req(REQ_FREE, 8'd0, 10'sd0);
    push_req(REQ_FREE, 8'd0, 10'sd0);
    push_req(REQ_FREE, 8'd2, 10'sd0);
    push_req(REQ_NOP, 8'd255, 10'sd511);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % SEG_LEN == 0) goal = goals[(n / SEG_LEN) % 8];
      if (n == 400) hold_req++;
      if (n == 700) calm = 1'b1;
      if (n == 950) calm = 1'b0;
      if (n == 1000 || n == 1500) drain();
      roll = $urandom_range(99);
      pa = (live < goal) ? 60 : 6;
      pf = (live > goal) ? 40 : 4;
      if (roll < pa) begin
        push_req(REQ_ALLOC, ID_W'($urandom), REQ_W'($urandom));
      end else if (roll < pa + pf) begin
        push_req(REQ_FREE, pick_live(), REQ_W'($urandom));
      end else if (roll < pa + pf + 6) begin
        // noise: any type on any slot
        push_req(req_type_e'($urandom_range(3)), ID_W'($urandom), REQ_W'($urandom));
      end else begin
        push_req(REQ_SET_HEIGHT, pick_live(), pick_height());
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("layer_zorder_stack_manager verification clean");
    end else begin
      $display("layer_zorder_stack_manager verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lzsm_pkg.sv
rtl/lzsm_step.sv
rtl/lzsm_store.sv
rtl/layer_zorder_stack_manager.sv
tb/layer_stack_checker.sv
tb/layer_zorder_stack_manager_tb.sv
